// ===== sv/rmts_pkg.sv =====
// rmts_pkg: shared types and constants for the rate monotonic tick scheduler.
// No dependencies; used by rmts_cell and rate_monotonic_tick_scheduler.
package rmts_pkg;

    // Task tables hold eight 8-bit entries.
    localparam int TABLE_TASKS = 8;
    localparam int FIELD_W     = 8;
    localparam int INDEX_W     = 3;
    localparam int COUNT_W     = 4;
    localparam int TABLE_W     = TABLE_TASKS * FIELD_W;
    localparam int TIME_W      = 32;

    // Defaults for top-level parameters.
    localparam int MAX_TASKS_DEFAULT = 8;
    localparam int TIME_BITS_DEFAULT = 8;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_TASK_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BURST_TABLE  = 2'd2;

    // Reset values of configuration registers.
    localparam logic [COUNT_W-1:0] TASK_COUNT_RESET   = 4'd1;
    localparam logic [TABLE_W-1:0] PERIOD_TABLE_RESET = 64'h0101_0101_0101_0101;
    localparam logic [TABLE_W-1:0] BURST_TABLE_RESET  = 64'h0;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    // Best candidate handed from cell to cell.
    typedef struct packed {
        logic                 valid;
        logic [FIELD_W-1:0]   period;
        logic [INDEX_W-1:0]   index;
    } best_t;

endpackage

// ===== sv/rate_monotonic_tick_scheduler.sv =====
// rate_monotonic_tick_scheduler: top level, config registers, cell chain and
// output register. Depends on rmts_pkg and rmts_cell.
//
// Usage:
//   Each beat on the s_ channel is one time tick; s_tdata[0] = restart clears
//   elapsed time, phases, remaining work and the last choice, and the tick is
//   then handled as tick 0. Each tick yields exactly one beat on the m_
//   channel: m_tuser[0] busy flag, m_tdata task index, changed flag and tick
//   time.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 task_count,
//   1 period_table, 2 burst_table) and cfg_data. cfg_ready is always high;
//   other indexes are ignored. Write only while no tick is in flight.
//   Result: registered; the beat for an accepted tick appears in the next cycle.
//   Throughput: one tick per cycle while results are not stalled. All selection
//   is combinational, through the row of task cells, each comparing its period
//   against the best candidate handed on by its lower-index neighbor.
//   Stall: s_tready = !m_tvalid || m_tready, so a new tick is taken in the
//   same cycle the waiting result leaves; a stalled result holds in place.
//   Reset (rst_n low, async): task_count 1, all periods 1, bursts 0, time
//   and task state cleared, no result pending, first result reports changed.
module rate_monotonic_tick_scheduler #(
    parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEFAULT,
    parameter int TIME_BITS = rmts_pkg::TIME_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // tick input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rmts_pkg::S_TDATA_W-1:0]     s_tdata,   // [0] restart, rest zero
    // result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rmts_pkg::M_TDATA_W-1:0]     m_tdata,   // [2:0] task_index,
                                                          // [3] changed,
                                                          // [35:4] tick_time,
                                                          // [39:36] zero
    output logic [rmts_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] busy_res
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rmts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rmts_pkg::TABLE_W-1:0]       cfg_data
);

    // Only eight tasks fit in the tables.
    localparam int NUM_CELLS = (MAX_TASKS < rmts_pkg::TABLE_TASKS) ?
                               MAX_TASKS : rmts_pkg::TABLE_TASKS;

    // ---------------- configuration registers ----------------
    logic [rmts_pkg::COUNT_W-1:0] task_count_reg;
    logic [rmts_pkg::TABLE_W-1:0] period_table_reg;
    logic [rmts_pkg::TABLE_W-1:0] burst_table_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg   <= rmts_pkg::TASK_COUNT_RESET;
            period_table_reg <= rmts_pkg::PERIOD_TABLE_RESET;
            burst_table_reg  <= rmts_pkg::BURST_TABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rmts_pkg::REG_TASK_COUNT:
                    task_count_reg <= cfg_data[rmts_pkg::COUNT_W-1:0];
                rmts_pkg::REG_PERIOD_TABLE:
                    period_table_reg <= cfg_data;
                rmts_pkg::REG_BURST_TABLE:
                    burst_table_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // ---------------- tick handshake ----------------
    logic tick;
    logic restart;

    assign s_tready = !m_tvalid || m_tready;
    assign tick     = s_tvalid && s_tready;
    assign restart  = s_tdata[0];

    // ---------------- cell chain ----------------
    rmts_pkg::best_t best_chain [NUM_CELLS+1];
    rmts_pkg::best_t best_final;

    assign best_chain[0] = '0;
    assign best_final    = best_chain[NUM_CELLS];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        logic enable;
        logic chosen;

        // a cell is enabled when its index is below task_count
        assign enable = (rmts_pkg::COUNT_W'(i) < task_count_reg);
        assign chosen = best_final.valid &&
                        (best_final.index == rmts_pkg::INDEX_W'(i));

        rmts_cell #(
            .CELL_INDEX (i),
            .TIME_BITS  (TIME_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tick     (tick),
            .restart  (restart),
            .enable   (enable),
            .period   (period_table_reg[i*rmts_pkg::FIELD_W +: rmts_pkg::FIELD_W]),
            .burst    (burst_table_reg[i*rmts_pkg::FIELD_W +: rmts_pkg::FIELD_W]),
            .chosen   (chosen),
            .best_in  (best_chain[i]),
            .best_out (best_chain[i+1])
        );
    end

    // ---------------- time and previous choice ----------------
    logic [rmts_pkg::TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic                         prev_seen_reg;   // low until first report
    logic                         prev_busy_reg;
    logic [rmts_pkg::INDEX_W-1:0] prev_index_reg;

    logic [rmts_pkg::TIME_W-1:0]  tick_time;
    logic                         seen_eff;
    logic                         changed;
    logic [rmts_pkg::INDEX_W-1:0] index_out;

    always_comb
    begin
        tick_time    = restart ? '0 : elapsed_reg;
        elapsed_next = tick_time + rmts_pkg::TIME_W'(1);
        seen_eff     = prev_seen_reg && !restart;
        index_out    = best_final.valid ? best_final.index : '0;
        changed      = !seen_eff ||
                       (prev_busy_reg != best_final.valid) ||
                       (best_final.valid && (prev_index_reg != best_final.index));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg    <= '0;
            prev_seen_reg  <= 1'b0;
            prev_busy_reg  <= 1'b0;
            prev_index_reg <= '0;
        end
        else if (tick)
        begin
            elapsed_reg    <= elapsed_next;
            prev_seen_reg  <= 1'b1;
            prev_busy_reg  <= best_final.valid;
            prev_index_reg <= index_out;
        end
    end

    // ---------------- output register ----------------
    logic                         out_valid_reg;
    logic                         out_busy_reg;
    logic [rmts_pkg::INDEX_W-1:0] out_index_reg;
    logic                         out_changed_reg;
    logic [rmts_pkg::TIME_W-1:0]  out_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            out_busy_reg    <= best_final.valid;
            out_index_reg   <= index_out;
            out_changed_reg <= changed;
            out_time_reg    <= tick_time;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_busy_reg;
    assign m_tdata  = {4'b0000, out_time_reg, out_changed_reg, out_index_reg};

    // ---------------- assertions ----------------
    // a restart tick reports time 0 and a change
    a_restart_report: assert property (@(posedge clk) disable iff (!rst_n)
        tick && restart |=> m_tvalid && (out_time_reg == '0) && out_changed_reg)
        else $error("restart tick did not report time 0 with changed set");

    // a reported running task is an enabled one
    a_busy_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        tick && best_final.valid |->
        (rmts_pkg::COUNT_W'(best_final.index) < task_count_reg))
        else $error("disabled task selected");

    // time only moves on an accepted tick
    a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> $stable(elapsed_reg))
        else $error("elapsed time moved without a tick");

    // a non-restart tick reports the count left by the previous tick
    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        tick && !restart |=> (out_time_reg == $past(elapsed_reg)))
        else $error("tick time does not follow elapsed count");

endmodule

// ===== sv/rmts_cell.sv =====
// rmts_cell: one task slot (phase counter, remaining work) and one link of the
// shortest-period selection chain. Depends on rmts_pkg.
module rmts_cell #(
    parameter int CELL_INDEX = 0,
    parameter int TIME_BITS  = rmts_pkg::TIME_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick,
    input  logic                         restart,
    input  logic                         enable,
    input  logic [rmts_pkg::FIELD_W-1:0] period,
    input  logic [rmts_pkg::FIELD_W-1:0] burst,
    input  logic                         chosen,
    input  rmts_pkg::best_t              best_in,
    output rmts_pkg::best_t              best_out
);

    localparam int CMP_W = (TIME_BITS + 1 > rmts_pkg::FIELD_W) ?
                           TIME_BITS + 1 : rmts_pkg::FIELD_W;

    logic [TIME_BITS-1:0]         phase_reg, phase_next;
    logic [rmts_pkg::FIELD_W-1:0] work_reg,  work_next;

    logic [TIME_BITS-1:0]         phase_eff;
    logic [rmts_pkg::FIELD_W-1:0] work_eff;
    logic [rmts_pkg::FIELD_W-1:0] work_rel;
    logic [TIME_BITS:0]           phase_inc;
    logic                         live;
    logic                         candidate;

    always_comb
    begin
        phase_eff = restart ? '0 : phase_reg;
        work_eff  = restart ? '0 : work_reg;
        live      = enable && (period != '0);
        // release reloads the burst, dropping leftover work
        work_rel  = (live && (phase_eff == '0)) ? burst : work_eff;
        candidate = live && (work_rel != '0);

        best_out = best_in;
        if (candidate && (!best_in.valid || (period < best_in.period)))
        begin
            best_out.valid  = 1'b1;
            best_out.period = period;
            best_out.index  = rmts_pkg::INDEX_W'(CELL_INDEX);
        end

        phase_inc = {1'b0, phase_eff} + {{TIME_BITS{1'b0}}, 1'b1};

        if (!enable)
        begin
            work_next  = '0;
            phase_next = '0;
        end
        else
        begin
            work_next = chosen ? (work_rel - rmts_pkg::FIELD_W'(1)) : work_rel;
            if ((period == '0) || phase_inc[TIME_BITS] ||
                (CMP_W'(phase_inc) >= CMP_W'(period)))
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_inc[TIME_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            work_reg  <= '0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            work_reg  <= work_next;
        end
    end

endmodule
